// ===== src/hmc_pkg.sv =====
// Shared types, codes and constants of the hashed multiset counter.
package hmc_pkg;

  localparam int BUCKETS_DEF    = 127;
  localparam int WAYS_DEF       = 4;
  localparam int COUNT_BITS_DEF = 16;

  localparam int KEY_W    = 32;
  localparam int MODE_W   = 2;
  localparam int OCC_W    = 16;
  localparam int TOTAL_W  = 25;
  localparam int STATUS_W = 2;

  // The bucket remainder is formed in three steps: a reciprocal product, a
  // back-multiply and subtract, and a final correction.
  localparam int MOD_STEPS = 3;
  localparam int STEP_W    = $clog2(MOD_STEPS);

  localparam int QUEUE_DEPTH = 2;

  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CALC = 3'b010,
    F_SEND = 3'b100
  } front_state_t;

  typedef enum logic [2:0] {
    B_CLEAR = 3'b001,
    B_IDLE  = 3'b010,
    B_EXEC  = 3'b100
  } back_state_t;

  typedef struct packed {
    logic                found;
    logic [OCC_W-1:0]    occurrences;
    logic [TOTAL_W-1:0]  total_elements;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

// ===== src/hmc_fifo.sv =====
// Small register queue with push/full and pop/empty sides.
module hmc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = hmc_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] dout
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== src/hmc_front.sv =====
// Front end: takes an item and forms the bucket index of its key.
module hmc_front #(
  parameter int BUCKETS = hmc_pkg::BUCKETS_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            block,
  input  logic                                            in_push,
  output logic                                            in_full,
  input  logic [hmc_pkg::MODE_W-1:0]                      in_mode,
  input  logic signed [hmc_pkg::KEY_W-1:0]                in_key,
  output logic                                            q_push,
  input  logic                                            q_full,
  output logic [hmc_pkg::MODE_W+hmc_pkg::KEY_W+$clog2(BUCKETS)-1:0] q_data
);

  localparam int BW = $clog2(BUCKETS);
  localparam int KW = hmc_pkg::KEY_W;
  localparam int SW = hmc_pkg::STEP_W;
  // Floor of 2^32 over BUCKETS; the quotient estimate it gives is at most one short.
  localparam logic [KW-1:0] RECIP = KW'(64'h1_0000_0000 / 64'(BUCKETS));

  hmc_pkg::front_state_t        state_r, state_nxt;
  logic [hmc_pkg::MODE_W-1:0]   mode_r;
  logic [KW-1:0]                key_r;
  logic [KW-1:0]                mag_r;
  logic [KW-1:0]                quot_r;
  logic [BW+1:0]                part_r;
  logic [BW-1:0]                rem_r;
  logic [SW-1:0]                step_r;
  logic [2*KW-1:0]              prod;
  logic [KW-1:0]                back_prod;
  logic [KW-1:0]                diff;
  logic [BW+1:0]                part_fix;
  logic [BW-1:0]                bucket;
  logic                         accept;

  assign in_full = block || (state_r != hmc_pkg::F_IDLE);
  assign accept  = in_push && !in_full;
  assign q_push  = (state_r == hmc_pkg::F_SEND) && !q_full;

  // Non-negative remainder: a negative key with a nonzero remainder wraps.
  assign bucket = (key_r[KW-1] && (rem_r != '0)) ? BW'(BUCKETS) - rem_r : rem_r;
  assign q_data = {mode_r, key_r, bucket};

  // Remainder of the key magnitude by reciprocal multiplication. The three
  // registers quot_r, part_r and rem_r form a short pipeline over the held
  // magnitude, so rem_r holds the reduced value once the calculation state ends.
  assign prod      = mag_r * RECIP;
  assign back_prod = quot_r * KW'(BUCKETS);
  assign diff      = mag_r - back_prod;

  always_comb begin
    part_fix = part_r;
    if (part_fix >= (BW+2)'(2 * BUCKETS)) begin
      part_fix = part_fix - (BW+2)'(2 * BUCKETS);
    end
    if (part_fix >= (BW+2)'(BUCKETS)) begin
      part_fix = part_fix - (BW+2)'(BUCKETS);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hmc_pkg::F_IDLE: begin
        if (accept) state_nxt = hmc_pkg::F_CALC;
      end
      hmc_pkg::F_CALC: begin
        if (step_r == SW'(hmc_pkg::MOD_STEPS-1)) state_nxt = hmc_pkg::F_SEND;
      end
      hmc_pkg::F_SEND: begin
        if (!q_full) state_nxt = hmc_pkg::F_IDLE;
      end
      default: state_nxt = hmc_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hmc_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      key_r  <= in_key;
      mag_r  <= in_key[KW-1] ? KW'(-in_key) : KW'(in_key);
      step_r <= '0;
    end else if (state_r == hmc_pkg::F_CALC) begin
      quot_r <= prod[2*KW-1:KW];
      part_r <= diff[BW+1:0];
      rem_r  <= part_fix[BW-1:0];
      step_r <= step_r + 1'b1;
    end
  end

endmodule

// ===== src/hmc_back.sv =====
// Back end: bucket memory, clearing pass and read-modify-write of one way.
module hmc_back #(
  parameter int BUCKETS    = hmc_pkg::BUCKETS_DEF,
  parameter int WAYS       = hmc_pkg::WAYS_DEF,
  parameter int COUNT_BITS = hmc_pkg::COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  output logic                   clearing,
  input  logic                   q_empty,
  output logic                   q_pop,
  input  logic [hmc_pkg::MODE_W+hmc_pkg::KEY_W+$clog2(BUCKETS)-1:0] q_data,
  input  logic                   r_full,
  output logic                   r_push,
  output hmc_pkg::result_t       r_data
);

  localparam int BW  = $clog2(BUCKETS);
  localparam int KW  = hmc_pkg::KEY_W;
  localparam int CB  = COUNT_BITS;
  localparam int WIW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TW  = hmc_pkg::TOTAL_W;

  logic [WAYS-1:0]    mem_v [BUCKETS];
  logic [WAYS*KW-1:0] mem_k [BUCKETS];
  logic [WAYS*CB-1:0] mem_c [BUCKETS];

  hmc_pkg::back_state_t       state_r, state_nxt;
  logic [BW-1:0]              clr_idx_r;
  logic [TW-1:0]              total_r, total_nxt;
  logic [hmc_pkg::MODE_W-1:0] mode_r;
  logic [KW-1:0]              key_r;
  logic [BW-1:0]              bkt_r;
  logic [WAYS-1:0]            rv_r, nv;
  logic [WAYS*KW-1:0]         rk_r, nk;
  logic [WAYS*CB-1:0]         rc_r, nc;
  logic                       start;
  logic                       wr_en;
  logic [BW-1:0]              wr_addr;
  logic                       hit, free;
  logic [WIW-1:0]             hit_idx, free_idx;
  logic [CB-1:0]              cnt_cur, cnt_new;
  logic [hmc_pkg::STATUS_W-1:0] status;

  assign clearing = (state_r == hmc_pkg::B_CLEAR);
  assign start    = (state_r == hmc_pkg::B_IDLE) && !q_empty && !r_full;
  assign q_pop    = start;
  assign r_push   = (state_r == hmc_pkg::B_EXEC);
  assign wr_en    = clearing || r_push;
  assign wr_addr  = clearing ? clr_idx_r : bkt_r;

  // Lowest matching way and lowest free way of the bucket just read.
  always_comb begin
    hit      = 1'b0;
    free     = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (rv_r[w] && (rk_r[w*KW +: KW] == key_r)) begin
        hit     = 1'b1;
        hit_idx = WIW'(w);
      end
      if (!rv_r[w]) begin
        free     = 1'b1;
        free_idx = WIW'(w);
      end
    end
  end

  assign cnt_cur = hit ? rc_r[hit_idx*CB +: CB] : '0;

  always_comb begin
    nv        = rv_r;
    nk        = rk_r;
    nc        = rc_r;
    total_nxt = total_r;
    cnt_new   = cnt_cur;
    status    = hmc_pkg::ST_DONE;
    case (mode_r)
      hmc_pkg::MODE_ADD: begin
        if (total_r == {TW{1'b1}}) begin
          status = hmc_pkg::ST_FULL;
        end else if (hit) begin
          if (cnt_cur == {CB{1'b1}}) begin
            status = hmc_pkg::ST_FULL;
          end else begin
            cnt_new                 = cnt_cur + 1'b1;
            nc[hit_idx*CB +: CB]    = cnt_new;
            total_nxt               = total_r + 1'b1;
          end
        end else if (free) begin
          cnt_new                 = CB'(1);
          nv[free_idx]            = 1'b1;
          nk[free_idx*KW +: KW]   = key_r;
          nc[free_idx*CB +: CB]   = cnt_new;
          total_nxt               = total_r + 1'b1;
        end else begin
          status = hmc_pkg::ST_FULL;
        end
      end
      hmc_pkg::MODE_REMOVE: begin
        if (hit) begin
          if (cnt_cur <= CB'(1)) begin
            cnt_new     = '0;
            nv[hit_idx] = 1'b0;
          end else begin
            cnt_new = cnt_cur - 1'b1;
          end
          nc[hit_idx*CB +: CB] = cnt_new;
          if (total_r != '0) total_nxt = total_r - 1'b1;
        end else begin
          status = hmc_pkg::ST_ABSENT;
        end
      end
      default: begin
        status = hmc_pkg::ST_DONE;
      end
    endcase
  end

  assign r_data.found          = hit;
  assign r_data.occurrences    = hmc_pkg::OCC_W'(cnt_new);
  assign r_data.total_elements = total_nxt;
  assign r_data.status         = status;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hmc_pkg::B_CLEAR: begin
        if (clr_idx_r == BW'(BUCKETS-1)) state_nxt = hmc_pkg::B_IDLE;
      end
      hmc_pkg::B_IDLE: begin
        if (start) state_nxt = hmc_pkg::B_EXEC;
      end
      hmc_pkg::B_EXEC: begin
        state_nxt = hmc_pkg::B_IDLE;
      end
      default: state_nxt = hmc_pkg::B_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= hmc_pkg::B_CLEAR;
      clr_idx_r <= '0;
      total_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (clearing) clr_idx_r <= clr_idx_r + 1'b1;
      if (r_push) total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mode_r <= q_data[BW+KW +: hmc_pkg::MODE_W];
      key_r  <= q_data[BW +: KW];
      bkt_r  <= q_data[BW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_v[wr_addr] <= clearing ? '0 : nv;
      mem_k[wr_addr] <= nk;
      mem_c[wr_addr] <= nc;
    end
    if (start) begin
      rv_r <= mem_v[q_data[BW-1:0]];
      rk_r <= mem_k[q_data[BW-1:0]];
      rc_r <= mem_c[q_data[BW-1:0]];
    end
  end

endmodule

// ===== src/hashed_multiset_counter.sv =====
// Front end, item queue, back end and result queue form the multiset counter.
// Path: the front end registers the item, forms the bucket remainder in its
// calculation state and hands the item to the item queue; the back end reads the
// bucket, writes it back and pushes the result into the result queue. The front
// end takes no new item until it has handed the last one to the item queue.
// Reset: synchronous active-low rst_n empties both queues, zeroes the total and
// starts a clearing pass over every bucket of the bucket memory with in_full high.
module hashed_multiset_counter #(
  parameter int BUCKETS    = hmc_pkg::BUCKETS_DEF,
  parameter int WAYS       = hmc_pkg::WAYS_DEF,
  parameter int COUNT_BITS = hmc_pkg::COUNT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic [hmc_pkg::MODE_W-1:0]           in_mode,
  input  logic signed [hmc_pkg::KEY_W-1:0]     in_key,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output logic                                 out_found,
  output logic [hmc_pkg::OCC_W-1:0]            out_occurrences,
  output logic [hmc_pkg::TOTAL_W-1:0]          out_total_elements,
  output logic [hmc_pkg::STATUS_W-1:0]         out_status
);

  // Each queued item carries its mode, its key and the bucket that the front
  // end worked out for it.
  localparam int QW = hmc_pkg::MODE_W + hmc_pkg::KEY_W + $clog2(BUCKETS);
  localparam int RW = $bits(hmc_pkg::result_t);

  logic             clearing;
  logic             fq_push, fq_full, fq_pop, fq_empty;
  logic [QW-1:0]    fq_din, fq_dout;
  logic             rq_push, rq_full;
  hmc_pkg::result_t rq_din, rq_dout;

  // The front end stays closed while the back end clears its memory, so no
  // item is looked up in a bucket that still holds stale valid bits.
  hmc_front #(
    .BUCKETS (BUCKETS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .block   (clearing),
    .in_push (in_push),
    .in_full (in_full),
    .in_mode (in_mode),
    .in_key  (in_key),
    .q_push  (fq_push),
    .q_full  (fq_full),
    .q_data  (fq_din)
  );

  // The item queue lets the front end start on the next key while the back end
  // waits for room in the result queue.
  hmc_fifo #(
    .WIDTH (QW)
  ) u_item_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_push),
    .full  (fq_full),
    .din   (fq_din),
    .pop   (fq_pop),
    .empty (fq_empty),
    .dout  (fq_dout)
  );

  // The back end reads a whole bucket when it starts an item and writes it back with
  // the one changed way from its execute state, so a following item of the same bucket
  // always sees the update.
  hmc_back #(
    .BUCKETS    (BUCKETS),
    .WAYS       (WAYS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .clearing (clearing),
    .q_empty  (fq_empty),
    .q_pop    (fq_pop),
    .q_data   (fq_dout),
    .r_full   (rq_full),
    .r_push   (rq_push),
    .r_data   (rq_din)
  );

  // The result queue holds finished results until the consumer takes a
  // transfer; the back end only starts an item when a slot is free.
  hmc_fifo #(
    .WIDTH (RW)
  ) u_result_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rq_push),
    .full  (rq_full),
    .din   (rq_din),
    .pop   (out_pop),
    .empty (out_empty),
    .dout  (rq_dout)
  );

  assign out_found          = rq_dout.found;
  assign out_occurrences    = rq_dout.occurrences;
  assign out_total_elements = rq_dout.total_elements;
  assign out_status         = rq_dout.status;

endmodule

// ===== src/hmc_checker.sv =====
// Port checker of the multiset counter and its bind to the top level.
module hmc_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_full,
  input logic                                 out_empty,
  input logic                                 out_pop,
  input logic                                 out_found,
  input logic [hmc_pkg::OCC_W-1:0]            out_occurrences,
  input logic [hmc_pkg::TOTAL_W-1:0]          out_total_elements,
  input logic [hmc_pkg::STATUS_W-1:0]         out_status
);

  a_full_after_reset: assert property (@(posedge clk) !rst_n |=> in_full)
    else $error("input side open right after reset");

  a_empty_after_reset: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result shown right after reset");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_status)
      && $stable(out_occurrences) && $stable(out_total_elements)))
    else $error("waiting result changed");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_status == hmc_pkg::ST_DONE || out_status == hmc_pkg::ST_ABSENT
      || out_status == hmc_pkg::ST_FULL))
    else $error("undefined status code");

  a_absent_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status == hmc_pkg::ST_ABSENT) |-> (!out_found && out_occurrences == '0))
    else $error("absent-key result reports a count");

endmodule

bind hashed_multiset_counter hmc_checker u_hmc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_full            (in_full),
  .out_empty          (out_empty),
  .out_pop            (out_pop),
  .out_found          (out_found),
  .out_occurrences    (out_occurrences),
  .out_total_elements (out_total_elements),
  .out_status         (out_status)
);

// ===== tb/hashed_multiset_counter_checker.sv =====
// Checker for the hashed multiset counter: mirrors the store and compares every result.
`timescale 1ns / 1ps
module hashed_multiset_counter_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  input  logic                          in_full,
  input  logic [hmc_pkg::MODE_W-1:0]    in_mode,
  input  logic [hmc_pkg::KEY_W-1:0]     in_key,
  input  logic                          out_empty,
  input  logic                          out_pop,
  input  logic                          out_found,
  input  logic [hmc_pkg::OCC_W-1:0]     out_occurrences,
  input  logic [hmc_pkg::TOTAL_W-1:0]   out_total_elements,
  input  logic [hmc_pkg::STATUS_W-1:0]  out_status,
  output int                            fail_count,
  output int                            pending_count
);

  localparam int NB      = hmc_pkg::BUCKETS_DEF;
  localparam int NW      = hmc_pkg::WAYS_DEF;
  localparam int ENTRIES = NB * NW;
  localparam int KW      = hmc_pkg::KEY_W;
  localparam int MW      = hmc_pkg::MODE_W;
  localparam int OW      = hmc_pkg::OCC_W;
  localparam int CW      = hmc_pkg::COUNT_BITS_DEF;
  localparam int TW      = hmc_pkg::TOTAL_W;
  localparam logic [CW-1:0] COUNT_FULL = '1;
  localparam logic [TW-1:0] TOTAL_FULL = '1;

  logic [KW-1:0]             mirror_key [ENTRIES];
  logic [CW-1:0]             mirror_count [ENTRIES];
  logic                      mirror_used [ENTRIES];
  logic [TW-1:0]             mirror_total;
  hmc_pkg::result_t          expected_results [$];

  assign pending_count = expected_results.size();

  function automatic int bucket_index(logic [KW-1:0] key);
    int r;
    r = $signed(key) % NB;
    if (r < 0) r += NB;
    return r;
  endfunction

  function automatic hmc_pkg::result_t apply_item(logic [MW-1:0] mode, logic [KW-1:0] key);
    hmc_pkg::result_t res;
    int base, hit, free_way;
    base = bucket_index(key) * NW;
    hit = -1;
    free_way = -1;
    for (int w = 0; w < NW; w++) begin
      if (mirror_used[base+w]) begin
        if (hit < 0 && mirror_key[base+w] == key) hit = base + w;
      end else if (free_way < 0) begin
        free_way = base + w;
      end
    end
    res = '0;
    res.found = (hit >= 0);
    if (hit >= 0) res.occurrences = OW'(mirror_count[hit]);
    res.status = hmc_pkg::ST_DONE;
    if (mode == hmc_pkg::MODE_ADD) begin
      if (mirror_total == TOTAL_FULL) begin
        res.status = hmc_pkg::ST_FULL;
      end else if (hit >= 0) begin
        if (mirror_count[hit] == COUNT_FULL) begin
          res.status = hmc_pkg::ST_FULL;
        end else begin
          mirror_count[hit] += 1'b1;
          res.occurrences = OW'(mirror_count[hit]);
          mirror_total += 1'b1;
        end
      end else if (free_way >= 0) begin
        mirror_used[free_way] = 1'b1;
        mirror_key[free_way] = key;
        mirror_count[free_way] = 1;
        res.occurrences = 1;
        mirror_total += 1'b1;
      end else begin
        res.status = hmc_pkg::ST_FULL;
      end
    end else if (mode == hmc_pkg::MODE_REMOVE) begin
      if (hit >= 0) begin
        if (mirror_count[hit] <= 1) begin
          mirror_used[hit] = 1'b0;
          mirror_count[hit] = 0;
          res.occurrences = 0;
        end else begin
          mirror_count[hit] -= 1'b1;
          res.occurrences = OW'(mirror_count[hit]);
        end
        if (mirror_total > 0) mirror_total -= 1'b1;
      end else begin
        res.status = hmc_pkg::ST_ABSENT;
      end
    end
    res.total_elements = mirror_total;
    return res;
  endfunction

  always @(posedge clk) begin
    hmc_pkg::result_t want;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        mirror_used[i] = 1'b0;
        mirror_count[i] = '0;
        mirror_key[i] = '0;
      end
      mirror_total = '0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (in_push && !in_full) expected_results.push_back(apply_item(in_mode, in_key));
      if (out_pop && !out_empty) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result transfer at %0t", $realtime);
        end else begin
          want = expected_results.pop_front();
          if (want.found !== out_found || want.occurrences !== out_occurrences ||
              want.total_elements !== out_total_elements || want.status !== out_status) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected found %0d occ %0d total %0d status %0d, got %0d %0d %0d %0d",
                       want.found, want.occurrences, want.total_elements, want.status,
                       out_found, out_occurrences, out_total_elements, out_status);
          end
        end
      end
    end
  end
endmodule

// ===== tb/hashed_multiset_counter_test.sv =====
// Top of the testbench: clock, reset, stimulus, receiver stalls and the verdict.
`timescale 1ns / 1ps
module hashed_multiset_counter_test;

  localparam int KW = hmc_pkg::KEY_W;
  localparam int MW = hmc_pkg::MODE_W;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic [MW-1:0] in_mode = hmc_pkg::MODE_QUERY;
  logic signed [KW-1:0] in_key = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic out_found;
  logic [hmc_pkg::OCC_W-1:0] out_occurrences;
  logic [hmc_pkg::TOTAL_W-1:0] out_total_elements;
  logic [hmc_pkg::STATUS_W-1:0] out_status;
  int fail_count;
  int pending_count;
  // The receiver reads this to know when to run without stalls, and when to hold off.
  int sent_count = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  hashed_multiset_counter DUT (
    .clk, .rst_n, .in_push, .in_full, .in_mode, .in_key,
    .out_empty, .out_pop, .out_found, .out_occurrences,
    .out_total_elements, .out_status
  );

  hashed_multiset_counter_checker checker_inst (
    .clk, .rst_n, .in_push, .in_full, .in_mode, .in_key,
    .out_empty, .out_pop, .out_found, .out_occurrences,
    .out_total_elements, .out_status, .fail_count, .pending_count
  );

  // Most keys come from a small pool sharing buckets 0 to 3, so that buckets fill up,
  // counts climb and removes meet present keys. Each pool key is a bucket plus a multiple of 127.
  function automatic logic [KW-1:0] pick_key();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return KW'($signed($urandom_range(0, 3)) + 127 * ($signed($urandom_range(0, 6)) - 3));
    if (sel < 85) return $urandom();
    if (sel < 90) return 32'h8000_0000 + $urandom_range(0, 3);
    if (sel < 95) return 32'h7fff_ffff - $urandom_range(0, 3);
    return KW'(-$signed($urandom_range(0, 300)));
  endfunction

  // One transfer; idles at random before it unless the quiet stretch is on.
  task automatic send_item(input logic [MW-1:0] mode, input logic [KW-1:0] key);
    if (!(sent_count >= 400 && sent_count < 600)) begin
      while ($urandom_range(0, 99) < 21) begin
        in_push <= 1'b0;
        @(negedge clk);
      end
    end
    in_push <= 1'b1;
    in_mode <= mode;
    in_key <= key;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sent_count++;
    @(negedge clk);
  endtask

  // Receiver: random stalls, a quiet stretch, and one long hold-off that fills the block.
  initial begin
    int hold;
    bit held_done;
    held_done = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held_done && sent_count >= 900) begin
        held_done = 1'b1;
        out_pop <= 1'b0;
        for (hold = 0; hold < 300; hold++) @(negedge clk);
      end
      if (sent_count >= 400 && sent_count < 600) out_pop <= 1'b1;
      else out_pop <= ($urandom_range(0, 99) >= 21);
    end
  end

  initial begin
    int mode_pick;
    int drain;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // Directed part: extremes of the key, every mode, an absent remove, the last
    // occurrence freed, a full bucket refusing a new key, and mode three as a query.
    send_item(hmc_pkg::MODE_REMOVE, 32'sd5);
    send_item(hmc_pkg::MODE_ADD, 32'h8000_0000);
    send_item(hmc_pkg::MODE_ADD, 32'h7fff_ffff);
    send_item(hmc_pkg::MODE_ADD, 32'hffff_ffff);
    send_item(hmc_pkg::MODE_ADD, 32'hffff_ffff);
    send_item(hmc_pkg::MODE_QUERY, 32'hffff_ffff);
    send_item(hmc_pkg::MODE_SPARE, 32'h8000_0000);
    send_item(hmc_pkg::MODE_REMOVE, 32'hffff_ffff);
    send_item(hmc_pkg::MODE_REMOVE, 32'hffff_ffff);
    send_item(hmc_pkg::MODE_QUERY, 32'hffff_ffff);
    for (int i = 0; i < 5; i++) send_item(hmc_pkg::MODE_ADD, KW'(7 + 127 * i));
    send_item(hmc_pkg::MODE_QUERY, KW'(7 + 127 * 4));
    send_item(hmc_pkg::MODE_REMOVE, 32'sd7);
    send_item(hmc_pkg::MODE_ADD, KW'(7 + 127 * 4));
    send_item(hmc_pkg::MODE_ADD, 32'sd0);
    send_item(hmc_pkg::MODE_REMOVE, 32'sd0);
    send_item(hmc_pkg::MODE_QUERY, 32'h7fff_ffff);
    // Random part, weighted toward adds so that buckets fill.
    for (int n = 0; n < 1300; n++) begin
      mode_pick = $urandom_range(0, 99);
      if (mode_pick < 50) send_item(hmc_pkg::MODE_ADD, pick_key());
      else if (mode_pick < 80) send_item(hmc_pkg::MODE_REMOVE, pick_key());
      else if (mode_pick < 95) send_item(hmc_pkg::MODE_QUERY, pick_key());
      else send_item(hmc_pkg::MODE_SPARE, pick_key());
    end
    in_push <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    for (drain = 0; drain < 40; drain++) @(negedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #(12 * 200000);
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
